// ===== hdl/bpe_pkg.sv =====
package bpe_pkg;

    // Default geometry of the datapath
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 15;

    // Fixed width of the curve parameter port
    localparam int T_PARAM_W = 16;

    // Highest degree handled: quartic, five control values
    localparam int MAX_POINTS = 5;

    // Curve degree selector codes
    typedef enum logic [1:0] {
        OP_QUADRATIC = 2'd0,
        OP_CUBIC     = 2'd1,
        OP_QUARTIC   = 2'd2
    } op_t;

    // Control that travels alongside the lane data of each stage
    typedef struct packed {
        logic                 valid;
        logic [T_PARAM_W-1:0] t;
        logic [2:0]           levels;
    } ctrl_t;

endpackage

// ===== hdl/bpe_lerp_level.sv =====
module bpe_lerp_level #(
    parameter int VALUE_WIDTH = bpe_pkg::VALUE_WIDTH_DEF,
    parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF,
    parameter int LEVEL       = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpe_pkg::ctrl_t                ctrl_in,
    input  logic signed [VALUE_WIDTH-1:0] v_in  [bpe_pkg::MAX_POINTS + 1 - LEVEL],
    output bpe_pkg::ctrl_t                ctrl_out,
    output logic signed [VALUE_WIDTH-1:0] v_out [bpe_pkg::MAX_POINTS - LEVEL]
);

    localparam int LANES = bpe_pkg::MAX_POINTS - LEVEL;
    localparam int DW    = VALUE_WIDTH + 1;
    localparam int TW    = bpe_pkg::T_PARAM_W + 1;
    localparam int PW    = DW + TW;

    bpe_pkg::ctrl_t                ctrl_a_reg;
    bpe_pkg::ctrl_t                ctrl_b_reg;
    logic signed [VALUE_WIDTH-1:0] a_reg     [LANES];
    logic signed [PW-1:0]          prod_reg  [LANES];
    logic signed [PW-1:0]          prod_next [LANES];
    logic signed [VALUE_WIDTH-1:0] res_reg   [LANES];
    logic signed [VALUE_WIDTH-1:0] res_next  [LANES];
    logic signed [DW-1:0]          diff      [LANES];
    logic signed [PW-1:0]          quot      [LANES];
    logic signed [TW-1:0]          t_sig;
    logic                          bypass;

    // Stage A: difference of neighbors times t
    always_comb
    begin
        t_sig = $signed({1'b0, ctrl_in.t});
        for (int i = 0; i < LANES; i++)
        begin
            diff[i]      = DW'(v_in[i + 1]) - DW'(v_in[i]);
            prod_next[i] = PW'(diff[i]) * PW'(t_sig);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            a_reg[i]    <= v_in[i];
            prod_reg[i] <= prod_next[i];
        end
    end

    // Stage B: floor-shift the product and add to the left value;
    // pass values through once this level lies beyond the item's degree
    always_comb
    begin
        bypass = 3'(LEVEL) > ctrl_a_reg.levels;
        for (int i = 0; i < LANES; i++)
        begin
            quot[i]     = prod_reg[i] >>> T_FRAC_BITS;
            res_next[i] = bypass ? a_reg[i] : a_reg[i] + quot[i][VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_b_reg <= '0;
        end
        else
        begin
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    assign ctrl_out = ctrl_b_reg;
    assign v_out    = res_reg;

endmodule

// ===== hdl/bezier_point_eval_top.sv =====
// Pipeline: a result strobes on done once the beat taken on start has passed
// one input register, then two register stages for each of four lerp levels.
// Throughput: one beat per cycle; busy is always low and the receiver cannot stall.
// The lerp pipeline has eight stages, with one multiplier per lane per level.
// Reset (rst_n, asynchronous, active low) clears the valid bits; data is not reset.
module bezier_point_eval_top #(
    parameter int VALUE_WIDTH = bpe_pkg::VALUE_WIDTH_DEF,
    parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            operation,
    input  logic signed [VALUE_WIDTH-1:0]         p0,
    input  logic signed [VALUE_WIDTH-1:0]         p1,
    input  logic signed [VALUE_WIDTH-1:0]         p2,
    input  logic signed [VALUE_WIDTH-1:0]         p3,
    input  logic signed [VALUE_WIDTH-1:0]         p4,
    input  logic [bpe_pkg::T_PARAM_W-1:0]         t_param,
    output logic                                  done,
    output logic signed [VALUE_WIDTH-1:0]         point_value
);

    localparam logic [31:0] T_ONE = 32'(1) << T_FRAC_BITS;

    bpe_pkg::ctrl_t                ctrl_in_reg;
    bpe_pkg::ctrl_t                ctrl_in_next;
    logic signed [VALUE_WIDTH-1:0] v_in_reg [bpe_pkg::MAX_POINTS];

    bpe_pkg::ctrl_t                ctrl_l1;
    bpe_pkg::ctrl_t                ctrl_l2;
    bpe_pkg::ctrl_t                ctrl_l3;
    bpe_pkg::ctrl_t                ctrl_l4;
    logic signed [VALUE_WIDTH-1:0] v_l1 [4];
    logic signed [VALUE_WIDTH-1:0] v_l2 [3];
    logic signed [VALUE_WIDTH-1:0] v_l3 [2];
    logic signed [VALUE_WIDTH-1:0] v_l4 [1];

    // Decode the degree and saturate t at 1.0
    always_comb
    begin
        ctrl_in_next.valid = start;
        if (32'(t_param) > T_ONE)
        begin
            ctrl_in_next.t = T_ONE[bpe_pkg::T_PARAM_W-1:0];
        end
        else
        begin
            ctrl_in_next.t = t_param;
        end
        case (operation)
            bpe_pkg::OP_QUADRATIC: ctrl_in_next.levels = 3'd2;
            bpe_pkg::OP_CUBIC:     ctrl_in_next.levels = 3'd3;
            bpe_pkg::OP_QUARTIC:   ctrl_in_next.levels = 3'd4;
            default:               ctrl_in_next.levels = 3'd4;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_in_reg <= '0;
        end
        else
        begin
            ctrl_in_reg <= ctrl_in_next;
        end
    end

    // Capture the control values of the beat
    always_ff @(posedge clk)
    begin
        v_in_reg[0] <= p0;
        v_in_reg[1] <= p1;
        v_in_reg[2] <= p2;
        v_in_reg[3] <= p3;
        v_in_reg[4] <= p4;
    end

    bpe_lerp_level #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (1)
    ) u_level1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_in_reg),
        .v_in     (v_in_reg),
        .ctrl_out (ctrl_l1),
        .v_out    (v_l1)
    );

    bpe_lerp_level #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (2)
    ) u_level2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_l1),
        .v_in     (v_l1),
        .ctrl_out (ctrl_l2),
        .v_out    (v_l2)
    );

    bpe_lerp_level #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (3)
    ) u_level3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_l2),
        .v_in     (v_l2),
        .ctrl_out (ctrl_l3),
        .v_out    (v_l3)
    );

    bpe_lerp_level #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (4)
    ) u_level4 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_l3),
        .v_in     (v_l3),
        .ctrl_out (ctrl_l4),
        .v_out    (v_l4)
    );

    // Drive the result beat
    assign busy        = 1'b0;
    assign done        = ctrl_l4.valid;
    assign point_value = v_l4[0];

`ifndef SYNTHESIS
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 9))
        else $error("result beat without a matching input beat");

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##9 done)
        else $error("input beat lost in the pipeline");

    a_t_zero_gives_p0: assert property (@(posedge clk) disable iff (!rst_n)
        (start && t_param == '0) |-> ##9 (point_value == $past(p0, 9)))
        else $error("t of zero did not return the first control value");
`endif

endmodule

// ===== tb/bezier_point_checker.sv =====
module bezier_point_checker #(
    parameter int VW  = bpe_pkg::VALUE_WIDTH_DEF,
    parameter int TFB = bpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    operation,
    input  logic signed [VW-1:0]          p0,
    input  logic signed [VW-1:0]          p1,
    input  logic signed [VW-1:0]          p2,
    input  logic signed [VW-1:0]          p3,
    input  logic signed [VW-1:0]          p4,
    input  logic [bpe_pkg::T_PARAM_W-1:0] t_param,
    input  logic                          done,
    input  logic signed [VW-1:0]          point_value,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);

    localparam longint T_ONE = longint'(1) << TFB;

    logic signed [VW-1:0] expected_points[$];
    logic signed [VW-1:0] want;
    int                   fails;
    int                   seen;

    // de Casteljau: n control values, n-1 levels of floor lerps
    function automatic logic signed [VW-1:0] casteljau_point(
        input logic [1:0]                    op,
        input logic signed [VW-1:0]          c0,
        input logic signed [VW-1:0]          c1,
        input logic signed [VW-1:0]          c2,
        input logic signed [VW-1:0]          c3,
        input logic signed [VW-1:0]          c4,
        input logic [bpe_pkg::T_PARAM_W-1:0] t
    );
        longint lane[bpe_pkg::MAX_POINTS];
        longint tt;
        int     n;
        lane[0] = c0;
        lane[1] = c1;
        lane[2] = c2;
        lane[3] = c3;
        lane[4] = c4;
        tt = longint'(t);
        // saturate t above 1.0
        if (tt > T_ONE)
            tt = T_ONE;
        // the spare selector code falls through to quartic
        case (op)
            bpe_pkg::OP_QUADRATIC: n = 3;
            bpe_pkg::OP_CUBIC:     n = 4;
            default:               n = 5;
        endcase
        for (int lvl = n - 1; lvl >= 1; lvl--)
        begin
            for (int i = 0; i < lvl; i++)
            begin
                lane[i] = lane[i] + (((lane[i+1] - lane[i]) * tt) >>> TFB);
            end
        end
        return lane[0][VW-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // compare each result beat with the oldest expected point
            if (done === 1'b1)
            begin
                if (expected_points.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none actual %0d",
                             $time, point_value);
                end
                else
                begin
                    want = expected_points.pop_front();
                    seen++;
                    if (point_value !== want)
                    begin
                        fails++;
                        $display("%0t: point_value mismatch, expected %0d actual %0d",
                                 $time, want, point_value);
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                fails++;
                $display("%0t: done unknown, expected 0 or 1 actual %b", $time, done);
            end

            // predict on every accepted command beat
            if (start === 1'b1 && busy === 1'b0)
                expected_points.push_back(casteljau_point(operation, p0, p1, p2, p3, p4,
                                                          t_param));
        end
        fail_count <= fails;
        pending    <= expected_points.size();
        checked    <= seen;
    end

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int VW          = bpe_pkg::VALUE_WIDTH_DEF;
    localparam int TW          = bpe_pkg::T_PARAM_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 30;
    localparam int RAND_PER_PHASE = 367;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [TW-1:0] T_ONE = 16'd32768;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           operation;
    logic signed [VW-1:0] p0;
    logic signed [VW-1:0] p1;
    logic signed [VW-1:0] p2;
    logic signed [VW-1:0] p3;
    logic signed [VW-1:0] p4;
    logic [TW-1:0]        t_param;
    logic                 done;
    logic signed [VW-1:0] point_value;

    int fail_count;
    int pending;
    int checked;
    int degree_count[4];
    int saturated_t;

    bezier_point_eval_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .p0          (p0),
        .p1          (p1),
        .p2          (p2),
        .p3          (p3),
        .p4          (p4),
        .t_param     (t_param),
        .done        (done),
        .point_value (point_value)
    );

    bezier_point_checker #(.VW(VW), .TFB(bpe_pkg::T_FRAC_BITS_DEF)) point_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .p0          (p0),
        .p1          (p1),
        .p2          (p2),
        .p3          (p3),
        .p4          (p4),
        .t_param     (t_param),
        .done        (done),
        .point_value (point_value),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // stop a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: cycle limit reached with %0d points outstanding", $time, pending);
        $display("tb failed");
        $finish;
    end

    // hold start high until the beat is taken
    task automatic send_point(
        input logic [1:0]           op,
        input logic signed [VW-1:0] c0,
        input logic signed [VW-1:0] c1,
        input logic signed [VW-1:0] c2,
        input logic signed [VW-1:0] c3,
        input logic signed [VW-1:0] c4,
        input logic [TW-1:0]        t
    );
        start     <= 1'b1;
        operation <= op;
        p0        <= c0;
        p1        <= c1;
        p2        <= c2;
        p3        <= c3;
        p4        <= c4;
        t_param   <= t;
        degree_count[op]++;
        if (t > T_ONE)
            saturated_t++;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // drop start and put junk on the fields while idle
    task automatic idle_gap(input int idle_pct);
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct)
            n++;
        if (n > 0)
        begin
            start     <= 1'b0;
            operation <= 2'($urandom);
            p0        <= VW'($urandom);
            p1        <= VW'($urandom);
            p2        <= VW'($urandom);
            p3        <= VW'($urandom);
            p4        <= VW'($urandom);
            t_param   <= TW'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [VW-1:0] random_coord();
        case ($urandom_range(9))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return VW'($signed($urandom_range(2047)) - 1024);
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic logic [TW-1:0] random_t();
        case ($urandom_range(9))
            0:       return '0;
            1:       return T_ONE;
            2:       return TW'($urandom_range(65535, 32769));
            default: return TW'($urandom_range(32768));
        endcase
    endfunction

    initial
    begin
        logic [TW-1:0]        t_set[6];
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] lo;
        int                   idle_pct;

        t_set = '{16'd0, 16'd1, 16'd16384, 16'd32767, T_ONE, 16'hFFFF};
        degree_count = '{0, 0, 0, 0};
        saturated_t  = 0;

        start     <= 1'b0;
        operation <= bpe_pkg::OP_QUADRATIC;
        p0        <= '0;
        p1        <= '0;
        p2        <= '0;
        p3        <= '0;
        p4        <= '0;
        t_param   <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every degree and the spare code, against boundary values of t, alternating extremes
        for (int op = 0; op < 4; op++)
        begin
            hi = (op % 2 == 0) ? V_MAX : V_MIN;
            lo = (op % 2 == 0) ? V_MIN : V_MAX;
            for (int k = 0; k < 6; k++)
                send_point(op[1:0], hi, lo, hi, (op == 0) ? random_coord() : lo,
                           (op < 2) ? random_coord() : hi, t_set[k]);
        end
        send_point(bpe_pkg::OP_QUARTIC, '0, '0, '0, '0, '0, T_ONE);

        // random: sender idles 19 percent, then 78 percent, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 78 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                idle_gap(idle_pct);
                send_point(2'($urandom_range(3)), random_coord(), random_coord(),
                           random_coord(), random_coord(), random_coord(), random_t());
            end
        end
        start <= 1'b0;

        // drain outstanding points, then let the pipeline settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending != 0)
            $display("%0t: %0d expected points never arrived", $time, pending);
        $display("covered %0d quadratic, %0d cubic, %0d quartic, %0d spare-code evaluations",
                 degree_count[0], degree_count[1], degree_count[2], degree_count[3]);
        $display("checked %0d points, %0d with t above 1.0", checked, saturated_t);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
